[sv/hashed_key_index_table_assert.svh]
// Assertion macros for the hashed key index table.
// Used by the top level only; needs the clock and reset names in scope.
`ifndef HASHED_KEY_INDEX_TABLE_ASSERT_SVH
`define HASHED_KEY_INDEX_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define HKIT_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("hkit assertion failed");
`define HKIT_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("hkit assertion failed");
`else
`define HKIT_ASSERT_NOW(lbl, pre, post)
`define HKIT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[sv/hkit_pkg.sv]
// Shared constants and types of the hashed key index table.
// No dependencies.
`timescale 1ns / 1ps
package hkit_pkg;
   localparam int HKIT_SLOTS   = 1024;
   localparam int HKIT_MAX_KEY = 64;

   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
   // The FNV prime is 2^40 + 2^8 + 0xB3.
   localparam logic [7:0]  FNV_PRIME_LOW = 8'hB3;

   localparam logic [3:0] SLOT_BITS_RESET = 4'd10;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_FOUND     = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_TOO_LONG  = 3'd4;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_FIND   = 1'b1;

   typedef struct packed {
      logic slot_we;
      logic key_we;
   } mem_ctl_type;
endpackage

[sv/hkit_fnv.sv]
// Running 64-bit FNV-1a hash, folded one byte per cycle while fold is high.
// Depends on hkit_pkg.
`timescale 1ns / 1ps
module hkit_fnv import hkit_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        fold,
   input  logic        clear,
   input  logic [7:0]  byte_in,
   output logic [63:0] hash
);
   logic [63:0] hash_ff, hash_in, mixed;

   always_comb begin
      mixed = hash_ff ^ {56'd0, byte_in};
      hash_in = hash_ff;
      if (clear) begin
         hash_in = FNV_BASIS;
      end else if (fold) begin
         hash_in = (mixed << 40) + (mixed << 8) + (mixed * {56'd0, FNV_PRIME_LOW});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
      end else begin
         hash_ff <= hash_in;
      end
   end

   assign hash = hash_ff;
endmodule

[sv/hkit_slot_mem.sv]
// Slot table storage: one word per slot (valid, length, size, offset) and
// the stored key bytes. Depends on hkit_pkg.
`timescale 1ns / 1ps
module hkit_slot_mem import hkit_pkg::*; #(
   parameter int SW = 10,
   parameter int LW = 7,
   parameter int KW = 6
) (
   input  logic              clock,
   input  mem_ctl_type       ctl,
   input  logic [SW-1:0]     slot_addr,
   input  logic              wr_valid,
   input  logic [LW-1:0]     wr_len,
   input  logic [63:0]       wr_size,
   input  logic [63:0]       wr_offset,
   input  logic [KW-1:0]     byte_addr,
   input  logic [7:0]        wr_byte,
   output logic              rd_valid,
   output logic [LW-1:0]     rd_len,
   output logic [63:0]       rd_size,
   output logic [63:0]       rd_offset,
   output logic [7:0]        rd_byte
);
   localparam int WW = 1 + LW + 128;

   logic [WW-1:0] slot_mem [1 << SW];
   logic [7:0]    key_mem [1 << (SW + KW)];
   logic [WW-1:0] slot_q_ff;
   logic [7:0]    key_q_ff;

   always_ff @(posedge clock) begin
      if (ctl.slot_we) begin
         slot_mem[slot_addr] <= {wr_valid, wr_len, wr_size, wr_offset};
      end
      slot_q_ff <= slot_mem[slot_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.key_we) begin
         key_mem[{slot_addr, byte_addr}] <= wr_byte;
      end
      key_q_ff <= key_mem[{slot_addr, byte_addr}];
   end

   assign rd_valid  = slot_q_ff[WW-1];
   assign rd_len    = slot_q_ff[WW-2 -: LW];
   assign rd_size   = slot_q_ff[127:64];
   assign rd_offset = slot_q_ff[63:0];
   assign rd_byte   = key_q_ff;
endmodule

[sv/hashed_key_index_table.sv]
// Hashed key index table: key streaming, probe sequencer and result port.
// Depends on hkit_pkg, hkit_fnv, hkit_slot_mem and the assertion header.
//
// Usage: a key is sent one request per cycle on the req_ ports while busy is
// low, start high. A request with req_byte_present adds req_key_byte to the
// key; the request with req_key_last runs the operation with req_command,
// req_blob_size and req_blob_offset of that request. After the last request
// busy stays high while the sequencer walks the slot table: a start step,
// a probe and a check per probed slot (and a byte-check step for an occupied
// slot passed over without any byte compare), a read and a check or write
// per key byte compared (find) or copied (insert), then rsp_strobe marks the
// result for one cycle. A key too long is answered from the start step.
// The probe loop through the single-ported slot memory sets the rate, and no
// new key is accepted while busy is high. After reset the block clears the
// valid bits of all slots, one per cycle, with busy high until it is done;
// csr_we may write slot_bits anytime.
// The receiver cannot stall: each result is shown for one cycle only.
`timescale 1ns / 1ps
`include "hashed_key_index_table_assert.svh"
module hashed_key_index_table import hkit_pkg::*; #(
   parameter int SLOTS   = HKIT_SLOTS,
   parameter int MAX_KEY = HKIT_MAX_KEY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [7:0]  req_key_byte,
   input  logic        req_byte_present,
   input  logic        req_key_last,
   input  logic [63:0] req_blob_size,
   input  logic [63:0] req_blob_offset,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_found_size,
   output logic [63:0] rsp_found_offset,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);
   localparam int SW = $clog2(SLOTS);
   localparam int LW = $clog2(MAX_KEY + 1);
   localparam int KW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_START    = 4'd2;
   localparam logic [3:0] S_PROBE    = 4'd3;
   localparam logic [3:0] S_CHECK    = 4'd4;
   localparam logic [3:0] S_BYTE_RD  = 4'd5;
   localparam logic [3:0] S_BYTE_CHK = 4'd6;
   localparam logic [3:0] S_COPY_RD  = 4'd7;
   localparam logic [3:0] S_COPY_WR  = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [3:0]    slot_bits_ff, slot_bits_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [SW:0]   probes_ff, probes_in;
   logic [KW-1:0] byte_ff, byte_in;
   logic [LW-1:0] pend_len_ff, pend_len_in;
   logic          ovf_ff, ovf_in;
   logic          cmd_ff, cmd_in;
   logic [63:0]   size_ff, size_in, offset_ff, offset_in;
   logic          strobe_ff, strobe_in;
   logic [2:0]    status_ff, status_in;
   logic [63:0]   fsize_ff, fsize_in, foff_ff, foff_in;
   logic          came_from_read_ff;

   logic [7:0]    pend_mem [MAX_KEY];
   logic [7:0]    pend_q_ff;
   logic          accept, pend_we, fold, hash_clear;
   logic [63:0]   hash;
   logic [4:0]    eff_bits;
   logic [SW:0]   slot_count;
   logic [SW-1:0] slot_mask;
   logic [SW:0]   probes_next;
   logic [LW-1:0] byte_next;
   mem_ctl_type   mem_ctl;
   logic          rd_valid;
   logic [LW-1:0] rd_len;
   logic [63:0]   rd_size, rd_offset;
   logic [7:0]    rd_byte;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   // Active slot count: zero acts as one bit, clamped to the table size.
   always_comb begin
      eff_bits = {1'b0, slot_bits_ff};
      if (eff_bits == 5'd0) begin
         eff_bits = 5'd1;
      end
      if (eff_bits > 5'(SW)) begin
         eff_bits = 5'(SW);
      end
      slot_count = (SW + 1)'(1) << eff_bits;
      slot_mask  = SW'(slot_count - (SW + 1)'(1));
   end

   assign probes_next = probes_ff + (SW + 1)'(1);
   assign byte_next   = LW'(byte_ff) + LW'(1);

   assign pend_we = accept && req_byte_present && (pend_len_ff < LW'(MAX_KEY));
   assign fold    = pend_we;

   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_len_ff[KW-1:0]] <= req_key_byte;
      end
      pend_q_ff <= pend_mem[byte_ff];
   end

   hkit_fnv u_fnv (
      .clock   (clock),
      .reset   (reset),
      .fold    (fold),
      .clear   (hash_clear),
      .byte_in (req_key_byte),
      .hash    (hash)
   );

   hkit_slot_mem #(.SW(SW), .LW(LW), .KW(KW)) u_mem (
      .clock     (clock),
      .ctl       (mem_ctl),
      .slot_addr (idx_ff),
      .wr_valid  (state_ff != S_CLEAR),
      .wr_len    (pend_len_ff),
      .wr_size   (size_ff),
      .wr_offset (offset_ff),
      .byte_addr (byte_ff),
      .wr_byte   (pend_q_ff),
      .rd_valid  (rd_valid),
      .rd_len    (rd_len),
      .rd_size   (rd_size),
      .rd_offset (rd_offset),
      .rd_byte   (rd_byte)
   );

   always_comb begin
      state_in     = state_ff;
      slot_bits_in = csr_we ? csr_wdata : slot_bits_ff;
      idx_in       = idx_ff;
      probes_in    = probes_ff;
      byte_in      = byte_ff;
      pend_len_in  = pend_len_ff;
      ovf_in       = ovf_ff;
      cmd_in       = cmd_ff;
      size_in      = size_ff;
      offset_in    = offset_ff;
      strobe_in    = 1'b0;
      status_in    = status_ff;
      fsize_in     = 64'd0;
      foff_in      = 64'd0;
      mem_ctl      = '0;
      hash_clear   = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_ctl.slot_we = 1'b1;
            idx_in = idx_ff + SW'(1);
            if (idx_ff == {SW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_byte_present) begin
                  if (pend_len_ff < LW'(MAX_KEY)) begin
                     pend_len_in = pend_len_ff + LW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (req_key_last) begin
                  cmd_in    = req_command;
                  size_in   = req_blob_size;
                  offset_in = req_blob_offset;
                  state_in  = S_START;
               end
            end
         end
         S_START: begin
            idx_in    = hash[SW-1:0] & slot_mask;
            probes_in = '0;
            byte_in   = '0;
            if (ovf_ff) begin
               strobe_in = 1'b1;
               status_in = ST_TOO_LONG;
            end else begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (cmd_ff == CMD_INSERT && !rd_valid) begin
               mem_ctl.slot_we = 1'b1;
               if (pend_len_ff == '0) begin
                  strobe_in = 1'b1;
                  status_in = ST_INSERTED;
               end else begin
                  state_in = S_COPY_RD;
               end
            end else if (cmd_ff == CMD_FIND && !rd_valid) begin
               strobe_in = 1'b1;
               status_in = ST_NOT_FOUND;
            end else if (cmd_ff == CMD_FIND && rd_len == pend_len_ff) begin
               if (pend_len_ff == '0) begin
                  strobe_in = 1'b1;
                  status_in = ST_FOUND;
                  fsize_in  = rd_size;
                  foff_in   = rd_offset;
               end else begin
                  state_in = S_BYTE_RD;
               end
            end else begin
               state_in = S_BYTE_CHK;
            end
         end
         S_BYTE_RD: begin
            state_in = S_BYTE_CHK;
         end
         S_BYTE_CHK: begin
            // Also reached from the slot check when the slot is to be skipped.
            state_in = S_PROBE;
         end
         S_COPY_RD: begin
            state_in = S_COPY_WR;
         end
         S_COPY_WR: begin
            mem_ctl.key_we = 1'b1;
            if (byte_next == pend_len_ff) begin
               strobe_in = 1'b1;
               status_in = ST_INSERTED;
            end else begin
               byte_in  = byte_ff + KW'(1);
               state_in = S_COPY_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A byte check completes a match, moves to the next byte, skips this slot or
      // ends the search after the last active slot; a skipped slot from S_CHECK
      // lands here with a forced mismatch because the previous state was S_CHECK.
      if (state_ff == S_BYTE_CHK) begin
         if (rd_byte == pend_q_ff && came_from_read_ff) begin
            if (byte_next == pend_len_ff) begin
               strobe_in = 1'b1;
               status_in = ST_FOUND;
               fsize_in  = rd_size;
               foff_in   = rd_offset;
            end else begin
               byte_in  = byte_ff + KW'(1);
               state_in = S_BYTE_RD;
            end
         end else if (probes_next == slot_count) begin
            strobe_in = 1'b1;
            status_in = (cmd_ff == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
         end else begin
            probes_in = probes_next;
            idx_in    = (idx_ff + SW'(1)) & slot_mask;
            byte_in   = '0;
         end
      end

      if (strobe_in) begin
         state_in    = S_IDLE;
         pend_len_in = '0;
         ovf_in      = 1'b0;
         hash_clear  = 1'b1;
      end
   end

   // A compare is only real when it came through a byte read.
   always_ff @(posedge clock) begin
      if (reset) begin
         came_from_read_ff <= 1'b0;
      end else begin
         came_from_read_ff <= (state_ff == S_BYTE_RD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         slot_bits_ff <= SLOT_BITS_RESET;
         idx_ff       <= '0;
         probes_ff    <= '0;
         byte_ff      <= '0;
         pend_len_ff  <= '0;
         ovf_ff       <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_bits_ff <= slot_bits_in;
         idx_ff       <= idx_in;
         probes_ff    <= probes_in;
         byte_ff      <= byte_in;
         pend_len_ff  <= pend_len_in;
         ovf_ff       <= ovf_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      size_ff   <= size_in;
      offset_ff <= offset_in;
      status_ff <= status_in;
      fsize_ff  <= fsize_in;
      foff_ff   <= foff_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_found_size   = fsize_ff;
   assign rsp_found_offset = foff_ff;

   `HKIT_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe)
   `HKIT_ASSERT_NEXT(a_last_sets_busy, start && !busy && req_key_last, busy)
   `HKIT_ASSERT_NOW(a_zero_unless_found, rsp_strobe && rsp_status != ST_FOUND, rsp_found_size == 64'd0 && rsp_found_offset == 64'd0)
   `HKIT_ASSERT_NOW(a_probe_bound, state_ff == S_CHECK, probes_ff < slot_count)
endmodule
